// File: hdl/petct_pkg.sv
// Package: shared types, codes and constants of the per-task event count tracker.
package petct_pkg;

   localparam int DEF_MAX_TASKS = 256;

   // op codes
   localparam logic [2:0] OP_SWITCH    = 3'd0;
   localparam logic [2:0] OP_TICK      = 3'd1;
   localparam logic [2:0] OP_READ      = 3'd2;
   localparam logic [2:0] OP_INIT      = 3'd3;
   localparam logic [2:0] OP_FINI      = 3'd4;
   localparam logic [2:0] OP_INSTALL   = 3'd5;
   localparam logic [2:0] OP_UNINSTALL = 3'd6;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_SAMPLE  = 3'd1;
   localparam logic [2:0] ST_NOSLOT  = 3'd2;
   localparam logic [2:0] ST_ABSENT  = 3'd3;
   localparam logic [2:0] ST_INVALID = 3'd4;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  first_task;
      logic [7:0]  second_task;
      logic [63:0] counter_now;
      logic        sample_failed;
      logic [63:0] event_code;
      logic        clear_after;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] count_value;
   } rsp_type;

   // one table word
   typedef struct packed {
      logic        valid;
      logic [31:0] gen;
      logic [63:0] total;
      logic [63:0] snap;
   } entry_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EX1,
      S_RD2,
      S_EX2
   } ctl_state_type;

   typedef struct packed {
      logic clear;   // clearing sweep write
      logic accept;  // capture request, read first task
      logic exec;    // update cycle
      logic second;  // update acts on second task
      logic rd2;     // read second task
      logic finish;  // emit result
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic go_second;
   } ctl_sts_type;

endpackage

// File: hdl/petct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module petct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/petct_ctrl.sv
// Controller state machine: clearing sweep, accept, update and second-task steps.
module petct_ctrl
   import petct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd,
   output logic        busy
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_EX1;
         end
         S_EX1: begin
            state_in = sts.go_second ? S_RD2 : S_IDLE;
         end
         S_RD2: begin
            state_in = S_EX2;
         end
         S_EX2: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
         end
         S_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         S_EX1: begin
            cmd.exec   = 1'b1;
            cmd.finish = !sts.go_second;
         end
         S_RD2: begin
            cmd.rd2 = 1'b1;
         end
         S_EX2: begin
            cmd.exec   = 1'b1;
            cmd.second = 1'b1;
            cmd.finish = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // clearing sweep always follows reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> state_ff == S_CLEAR)
      else $error("clearing sweep not entered after reset");

   // second-task update only right after its read
   a_ex2_after_rd2: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EX2 |-> $past(state_ff) == S_RD2)
      else $error("second update without read");

   // results never on consecutive cycles
   a_finish_spaced: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !cmd.finish)
      else $error("back-to-back result transfers");

endmodule

// File: hdl/petct_datapath.sv
// Datapath: request register, task table, event slot, generation and result register.
module petct_datapath
   import petct_pkg::*;
#(
   parameter int MAX_TASKS = DEF_MAX_TASKS
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_cmd_type cmd,
   input  req_type     req_data,
   output ctl_sts_type sts,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int AW = $clog2(MAX_TASKS);

   req_type     req_ff, req_in;
   logic [63:0] inst_ff, inst_in;
   logic [31:0] gen_ff, gen_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   entry_type   rd_entry, ent, upd;
   logic        ram_wr_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   entry_type   ram_wr_data;

   logic [7:0]  cur_task;
   logic [31:0] cur_wide, t1_port_wide, t2_wide;
   logic [AW-1:0] cur_addr;
   logic        in_range, installed, stale, do_stop, do_start, do_add;
   logic [63:0] delta, base_total, read_val;
   logic [2:0]  step_status;
   logic        step_wr;

   // ---------------- table ----------------
   petct_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_entry)
   );

   assign t1_port_wide = 32'(req_data.first_task);
   assign t2_wide      = 32'(req_ff.second_task);
   assign ram_rd_addr  = cmd.rd2 ? t2_wide[AW-1:0] : t1_port_wide[AW-1:0];

   assign cur_task = cmd.second ? req_ff.second_task : req_ff.first_task;
   assign cur_wide = 32'(cur_task);
   assign cur_addr = cur_wide[AW-1:0];
   assign in_range = cur_wide < 32'(MAX_TASKS);

   assign ram_wr_en   = cmd.clear || (cmd.exec && step_wr);
   assign ram_wr_addr = cmd.clear ? clr_cnt_ff : cur_addr;
   assign ram_wr_data = cmd.clear ? entry_type'('0) : upd;

   // ---------------- entry update ----------------
   always_comb begin
      // an absent entry reads as freshly created
      ent = rd_entry.valid ? rd_entry : entry_type'('0);
      upd = ent;
      upd.valid   = 1'b1;
      step_wr     = 1'b0;
      step_status = ST_OK;
      read_val    = '0;
      installed   = inst_ff != 64'd0;
      stale       = ent.gen != gen_ff;
      delta       = req_ff.counter_now - ent.snap;
      base_total  = stale ? 64'd0 : ent.total;
      do_stop  = !cmd.second && req_ff.op == OP_SWITCH && req_ff.first_task != 8'd0;
      do_start = cmd.second || (req_ff.op == OP_TICK && req_ff.first_task != 8'd0);
      do_add   = !cmd.second;

      if (do_stop) begin
         if (!in_range) begin
            step_status = ST_ABSENT;
         end else begin
            step_wr = 1'b1;
            upd.gen = gen_ff;
            if (installed) begin
               if (stale) begin
                  upd.total = 64'd0;
               end else if (req_ff.sample_failed) begin
                  step_status = ST_SAMPLE;
                  upd.gen     = ent.gen;
               end else begin
                  upd.total = ent.total + delta;
               end
            end
         end
      end else if (do_start) begin
         if (!in_range) begin
            step_status = ST_ABSENT;
         end else begin
            step_wr = 1'b1;
            upd.gen = gen_ff;
            if (installed) begin
               upd.total = base_total;
               if (req_ff.sample_failed) begin
                  step_status = ST_SAMPLE;
                  upd.gen     = ent.gen;
               end else begin
                  if (do_add) upd.total = base_total + delta;
                  upd.snap = req_ff.counter_now;
               end
            end
         end
         // tick always answers ok
         if (!cmd.second) step_status = ST_OK;
      end else if (!cmd.second) begin
         case (req_ff.op)
            OP_READ: begin
               if (req_ff.event_code != inst_ff) begin
                  step_status = ST_INVALID;
               end else if (!in_range || !rd_entry.valid) begin
                  step_status = ST_ABSENT;
               end else begin
                  read_val = rd_entry.total;
                  if (req_ff.clear_after) begin
                     step_wr   = 1'b1;
                     upd       = rd_entry;
                     upd.total = 64'd0;
                  end
               end
            end
            OP_INIT: begin
               if (!in_range) begin
                  step_status = ST_ABSENT;
               end else begin
                  step_wr = 1'b1;
                  upd.gen = 32'd0;
               end
            end
            OP_FINI: begin
               if (in_range) begin
                  step_wr   = 1'b1;
                  upd       = rd_entry;
                  upd.valid = 1'b0;
               end
            end
            OP_INSTALL: begin
               if (installed) step_status = ST_NOSLOT;
            end
            OP_UNINSTALL: begin
               if (req_ff.event_code != inst_ff) step_status = ST_ABSENT;
            end
            default: begin
               step_status = ST_OK;
            end
         endcase
      end
   end

   assign sts.go_second = req_ff.op == OP_SWITCH && step_status == ST_OK
                          && req_ff.second_task != 8'd0;
   assign sts.clear_done = clr_cnt_ff == AW'(MAX_TASKS - 1);

   // ---------------- registers ----------------
   always_comb begin
      req_in = cmd.accept ? req_data : req_ff;
      inst_in = inst_ff;
      gen_in  = gen_ff;
      if (cmd.exec && !cmd.second) begin
         if (req_ff.op == OP_INSTALL && inst_ff == 64'd0) begin
            inst_in = req_ff.event_code;
            gen_in  = gen_ff + 32'd1;
         end else if (req_ff.op == OP_UNINSTALL && req_ff.event_code == inst_ff) begin
            inst_in = 64'd0;
            gen_in  = gen_ff + 32'd1;
         end
      end
      clr_cnt_in   = cmd.clear ? clr_cnt_ff + AW'(1) : clr_cnt_ff;
      rsp_valid_in = cmd.finish;
      rsp_in       = rsp_ff;
      if (cmd.finish) begin
         rsp_in.status      = step_status;
         rsp_in.count_value = read_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inst_ff      <= 64'd0;
         gen_ff       <= 32'd1;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inst_ff      <= inst_in;
         gen_ff       <= gen_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hdl/per_task_event_count_tracker_unit.sv
// Top level of the per-task event count tracker: controller plus datapath.
// Sequencing: the result strobe is registered; a switch that also starts a nonzero next task
//   makes two read-modify-write passes over the table RAM (EX1, then RD2 and EX2) before it.
// Requests: no new request is taken until the previous one has finished, as set by the
//   single read-modify-write path of the task table RAM with its registered read.
// Reset: synchronous; afterwards a clearing pass zeroes every table entry with busy held
//   high. Results cannot be stalled: rsp_valid lasts one cycle.
module per_task_event_count_tracker_unit
   import petct_pkg::*;
#(
   parameter int MAX_TASKS = DEF_MAX_TASKS
) (
   input  logic    clock,
   input  logic    reset,
   // request channel: transfer when start is high and busy is low
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   // result channel: one-cycle strobe
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // sequencing: clear sweep, accept, first update, optional second read/update
   petct_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   // table, event slot, generation counter and result register
   petct_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
